FILE: rtl/shbi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the string hash bucket index unit.
// No dependencies; used by the controller, the datapath and the top level.
package shbi_pkg;

  localparam int HASH_W           = 64;
  localparam int MASK_W           = 63;
  localparam int SIZE_W           = 32;
  localparam int CHAR_W           = 8;
  localparam int BIT_IDX_W        = $clog2(MASK_W);
  localparam int INDEX_WIDTH_DEF  = 32;

  localparam logic [SIZE_W-1:0]    TABLE_SIZE_RESET = SIZE_W'(1024);
  localparam logic [BIT_IDX_W-1:0] TOP_BIT          = BIT_IDX_W'(MASK_W - 1);
  localparam logic [CHAR_W-1:0]    TERMINATOR       = '0;

  // Controller to datapath.
  typedef struct packed {
    logic                 hash_step;  // fold the transferred byte into the hash
    logic                 capture;    // latch masked hash, clear hash, start divide
    logic                 div_step;   // one restoring-division step
    logic [BIT_IDX_W-1:0] bit_idx;    // dividend bit consumed by this step
    logic                 publish;    // load the output register
  } shbi_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic char_zero;  // presented byte is the terminator
    logic out_hold;   // output register full and not being taken
  } shbi_stat_t;

endpackage

FILE: rtl/shbi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the string hash unit: byte intake, divide steps, publish.
// Depends on shbi_pkg.
module shbi_ctrl
  import shbi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  shbi_stat_t stat,
  output logic       in_ready,
  output shbi_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 xfer;

  assign in_ready = (state == S_RUN);
  assign xfer     = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.hash_step = xfer && !stat.char_zero;
    cmd.capture   = xfer && stat.char_zero;
    cmd.div_step  = (state == S_DIV);
    cmd.bit_idx   = bit_idx;
    cmd.publish   = (state == S_DONE) && !stat.out_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_RUN;
      bit_idx <= TOP_BIT;
    end else begin
      case (state)
        S_RUN: begin
          if (xfer && stat.char_zero) begin
            state   <= S_DIV;
            bit_idx <= TOP_BIT;
          end
        end
        S_DIV: begin
          if (bit_idx == '0) begin
            state <= S_DONE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        S_DONE: begin
          // hold until the output register can take the result
          if (!stat.out_hold) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

FILE: rtl/shbi_dp.sv
`timescale 1ns / 1ps
// Datapath: running hash, table size register, restoring divider, output register.
// Depends on shbi_pkg.
module shbi_dp
  import shbi_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CHAR_W-1:0]      char_code,
  input  logic                   cfg_we,
  input  logic [SIZE_W-1:0]      cfg_data,
  input  logic                   out_ready,
  input  shbi_cmd_t              cmd,
  output shbi_stat_t             stat,
  output logic                   out_valid,
  output logic [INDEX_WIDTH-1:0] bucket_index,
  output logic [MASK_W-1:0]      masked_hash
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [SIZE_W-1:0] table_size;
  logic [MASK_W-1:0] dividend;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] rem_next;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic [HASH_W-1:0] index_wide;

  assign stat.char_zero = (char_code == TERMINATOR);
  assign stat.out_hold  = out_valid && !out_ready;

  // hash * 131 + signed byte, as shifts and adds
  assign running_hash_next = (running_hash << 7) + (running_hash << 1) + running_hash
                           + {{(HASH_W-CHAR_W){char_code[CHAR_W-1]}}, char_code};

  // one restoring-division step per cycle, MSB first
  assign shifted  = {rem, dividend[cmd.bit_idx]};
  assign diff     = shifted - {1'b0, table_size};
  assign rem_next = diff[SIZE_W] ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];

  // a zero table size yields index zero
  assign index_wide = (table_size == '0) ? '0 : {{(HASH_W-SIZE_W){1'b0}}, rem};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      table_size   <= TABLE_SIZE_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= cfg_data;
      end
      if (cmd.hash_step) begin
        running_hash <= running_hash_next;
      end else if (cmd.capture) begin
        running_hash <= '0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dividend <= running_hash[MASK_W-1:0];
      rem      <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.publish) begin
      bucket_index <= index_wide[INDEX_WIDTH-1:0];
      masked_hash  <= dividend;
    end
  end

endmodule

FILE: rtl/string_hash_bucket_index_unit.sv
`timescale 1ns / 1ps
// String hash bucket index unit: takes a string one byte per transfer and folds
// each nonzero byte (as a signed char) into a 64-bit hash, hash = hash*131 + byte.
// A zero byte ends the string: the hash with bit 63 cleared goes out as
// masked_hash, together with masked_hash modulo table_size as bucket_index, and
// the hash restarts from zero. Nonzero bytes are taken one per cycle. Once the
// terminator is taken, the input stalls while a bit-serial restoring divider runs
// and then the output register is loaded; a full output register that is not taken
// holds the unit after the divide. table_size is written by cfg_we/cfg_data; the
// user must write it only while idle, which the block itself does not enforce; a
// table size of zero gives bucket_index 0. Depends on shbi_pkg.
module string_hash_bucket_index_unit
  import shbi_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CHAR_W-1:0]      char_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_WIDTH-1:0] bucket_index,
  output logic [MASK_W-1:0]      masked_hash,
  input  logic                   cfg_we,
  input  logic [SIZE_W-1:0]      cfg_data
);

  shbi_cmd_t  cmd;
  shbi_stat_t stat;

  shbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  shbi_dp #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .bucket_index (bucket_index),
    .masked_hash  (masked_hash)
  );

`ifndef SYNTHESIS
  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && char_code != TERMINATOR && !out_valid) |=> !out_valid)
    else $error("result appeared after a nonzero byte");

  a_term_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && char_code == TERMINATOR) |=> !in_ready)
    else $error("input not stalled during divide");

  a_publish_stalled: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while input was open");
`endif

endmodule
